// ----- design/hdw_pkg.sv -----
// ----------------------------------------------------------------------------
// hdw_pkg
// Types, constants and the arctangent table for the heading to wheel speed
// block.
// ----------------------------------------------------------------------------
package hdw_pkg;

  localparam logic signed [16:0] ANGLE_PI      = 17'sd25736;
  localparam logic signed [16:0] ANGLE_HALF_PI = 17'sd12868;

  // turning modes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_SOFT = 2'd1;
  localparam logic [1:0] MODE_HARD = 2'd2;

  // vector classes found by the front end
  localparam logic [1:0] CLS_GEN   = 2'd0;
  localparam logic [1:0] CLS_YZERO = 2'd1;
  localparam logic [1:0] CLS_XZERO = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_HARD = 2'd0;
  localparam logic [1:0] REG_SOFT = 2'd1;
  localparam logic [1:0] REG_NONE = 2'd2;
  localparam logic [1:0] REG_MAX  = 2'd3;

  localparam int CNT_W    = 5;
  localparam int CW       = 27;  // cordic datapath width
  localparam int DIV_BITS = 31;

  typedef struct packed {
    logic signed [15:0] heading_x;
    logic signed [15:0] heading_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [1:0]         turn_mode;
  } out_beat_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [1:0]         cls;
  } work_t;

  typedef struct packed {
    logic [14:0] hard_thr;
    logic [14:0] soft_thr;
    logic [14:0] none_thr;
    logic [14:0] spd_limit;
  } cfg_t;

  // atan(2^-i) in Q3.13
  function automatic logic [12:0] atan_lut(input logic [CNT_W-1:0] i);
    logic [12:0] v;
    case (i)
      5'd0:    v = 13'd6434;
      5'd1:    v = 13'd3798;
      5'd2:    v = 13'd2007;
      5'd3:    v = 13'd1019;
      5'd4:    v = 13'd511;
      5'd5:    v = 13'd256;
      5'd6:    v = 13'd128;
      5'd7:    v = 13'd64;
      5'd8:    v = 13'd32;
      5'd9:    v = 13'd16;
      5'd10:   v = 13'd8;
      5'd11:   v = 13'd4;
      5'd12:   v = 13'd2;
      5'd13:   v = 13'd1;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/heading_to_differential_wheel_speeds_core.sv -----
// ----------------------------------------------------------------------------
// heading_to_differential_wheel_speeds_core
// Heading vector to differential wheel speeds with turning hysteresis.
//
//   channel | ports                          | direction
//   in      | in_valid, in_stall, in_data    | heading beat in
//   out     | out_valid, out_stall, out_data | wheel speed beat out
//   cfg     | cfg_we, cfg_index, cfg_wdata   | register write
//
// A soft turn adds a bit-serial divide; cordic and square root share one
// iteration loop.
// Reset is synchronous, active low; no clearing pass.
// A queue of two beats and a holding register sit ahead of the back end, and
// the output register frees the back end while a result waits.
// ----------------------------------------------------------------------------
module heading_to_differential_wheel_speeds_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hdw_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hdw_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_wdata
);

  hdw_pkg::cfg_t  cfg_r;
  logic           push, q_full, q_empty, pop;
  hdw_pkg::work_t push_data, pop_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hard_thr  <= 15'd12868;
      cfg_r.soft_thr  <= 15'd10008;
      cfg_r.none_thr  <= 15'd1430;
      cfg_r.spd_limit <= 15'd2560;
    end else if (cfg_we) begin
      case (cfg_index)
        hdw_pkg::REG_HARD: cfg_r.hard_thr  <= cfg_wdata;
        hdw_pkg::REG_SOFT: cfg_r.soft_thr  <= cfg_wdata;
        hdw_pkg::REG_NONE: cfg_r.none_thr  <= cfg_wdata;
        hdw_pkg::REG_MAX:  cfg_r.spd_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  hdw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  hdw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .pop_data  (pop_data)
  );

  hdw_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- design/hdw_front.sv -----
// ----------------------------------------------------------------------------
// hdw_front
// Accepts heading beats and tags each with its vector class.
// ----------------------------------------------------------------------------
module hdw_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  hdw_pkg::in_beat_t in_data,
  output logic             push,
  output hdw_pkg::work_t   push_data,
  input  logic             q_full
);

  logic            valid_r;
  hdw_pkg::work_t  item_r;
  logic            take;

  assign push      = valid_r & ~q_full;
  assign in_stall  = valid_r & q_full;
  assign take      = in_valid & ~in_stall;
  assign push_data = item_r;

  // holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (push) begin
      valid_r <= 1'b0;
    end
  end

  // classify the vector
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.x <= in_data.heading_x;
      item_r.y <= in_data.heading_y;
      if (in_data.heading_y == 16'sd0) begin
        item_r.cls <= hdw_pkg::CLS_YZERO;
      end else if (in_data.heading_x == 16'sd0) begin
        item_r.cls <= hdw_pkg::CLS_XZERO;
      end else begin
        item_r.cls <= hdw_pkg::CLS_GEN;
      end
    end
  end

endmodule

// ----- design/hdw_queue.sv -----
// ----------------------------------------------------------------------------
// hdw_queue
// Two-entry queue between front end and back end.
// ----------------------------------------------------------------------------
module hdw_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hdw_pkg::work_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output hdw_pkg::work_t pop_data
);

  hdw_pkg::work_t mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rd_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

// ----- design/hdw_back.sv -----
// ----------------------------------------------------------------------------
// hdw_back
// Cordic angle, square root length, mode update, soft turn divide and
// output register.
// ----------------------------------------------------------------------------
module hdw_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hdw_pkg::cfg_t     cfg,
  input  logic              q_empty,
  input  hdw_pkg::work_t    q_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output hdw_pkg::out_beat_t out_data
);

  localparam int ITERS = (CORDIC_STEPS > 16) ? CORDIC_STEPS : 16;
  localparam int CW = hdw_pkg::CW;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQX  = 7'b0000010,
    S_SQY  = 7'b0000100,
    S_ITER = 7'b0001000,
    S_MODE = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [15:0]   hx_r, hy_r;
  logic [1:0]           cls_r;
  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [16:0]   z_r;
  logic [31:0]          v_r, res_r, bit_r;
  logic [hdw_pkg::CNT_W-1:0] cnt_r;
  logic [1:0]           mode_r;
  logic [14:0]          base_r;
  logic                 pos_r;
  logic [30:0]          num_r;
  logic [15:0]          rem_r;
  logic                 dz_r;  // divide skipped, d is zero
  logic                 out_valid_r;
  hdw_pkg::out_beat_t   out_r;

  // shared squaring multiplier
  logic signed [15:0] sq_in;
  logic signed [31:0] sq;
  assign sq_in = state_r == S_SQX ? hx_r : hy_r;
  assign sq    = sq_in * sq_in;

  // cordic step
  logic signed [CW-1:0] xs, ys;
  logic signed [16:0]   at;
  assign xs = cx_r >>> cnt_r;
  assign ys = cy_r >>> cnt_r;
  assign at = {4'b0, hdw_pkg::atan_lut(cnt_r)};

  // root step
  logic [31:0] trial;
  assign trial = res_r + bit_r;

  // mode update on saturated angle
  logic signed [16:0] zs;
  logic [14:0]        a;
  logic [1:0]         m0, m1, m2, m3;
  always_comb begin
    zs = z_r;
    if (z_r > hdw_pkg::ANGLE_PI) zs = hdw_pkg::ANGLE_PI;
    if (z_r < -hdw_pkg::ANGLE_PI) zs = -hdw_pkg::ANGLE_PI;
    a = zs[16] ? 15'(-zs) : zs[14:0];
    m0 = (mode_r == hdw_pkg::MODE_SOFT || mode_r == hdw_pkg::MODE_HARD) ?
         mode_r : hdw_pkg::MODE_NONE;
    m1 = m0;
    if (m1 == hdw_pkg::MODE_HARD && a <= cfg.soft_thr) m1 = hdw_pkg::MODE_SOFT;
    m2 = m1;
    if (m2 == hdw_pkg::MODE_SOFT) begin
      if (a > cfg.hard_thr) m2 = hdw_pkg::MODE_HARD;
      else if (a <= cfg.none_thr) m2 = hdw_pkg::MODE_NONE;
    end
    m3 = m2;
    if (m3 == hdw_pkg::MODE_NONE) begin
      if (a > cfg.hard_thr) m3 = hdw_pkg::MODE_HARD;
      else if (a > cfg.none_thr) m3 = hdw_pkg::MODE_SOFT;
    end
  end

  logic [14:0] base_c;
  logic [29:0] prod;
  assign base_c = (res_r[15:0] < {1'b0, cfg.spd_limit}) ? res_r[14:0] : cfg.spd_limit;
  assign prod   = base_c * a;

  // divide step
  logic [15:0] rem_sh;
  logic        qbit;
  assign rem_sh = {rem_r[14:0], num_r[30]};
  assign qbit   = rem_sh >= {1'b0, cfg.hard_thr};

  // final speeds
  logic signed [17:0] d, s1, s2, lt, rt;
  logic               out_free;
  assign out_free = ~out_valid_r | ~out_stall;
  always_comb begin
    d = dz_r ? 18'sd0 : $signed({1'b0, num_r[16:0]});
    if (mode_r == hdw_pkg::MODE_HARD) begin
      s1 = -$signed({3'b0, cfg.spd_limit});
      s2 = $signed({3'b0, cfg.spd_limit});
    end else if (mode_r == hdw_pkg::MODE_SOFT) begin
      s1 = $signed({3'b0, base_r}) - d;
      s2 = $signed({3'b0, base_r}) + d;
    end else begin
      s1 = $signed({3'b0, base_r});
      s2 = s1;
    end
    lt = pos_r ? s1 : s2;
    rt = pos_r ? s2 : s1;
  end

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) r = 16'sh7fff;
    else if (v < -18'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  assign pop = (state_r == S_IDLE) & ~q_empty;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (!q_empty) state_nxt = S_SQX;
      S_SQX:  state_nxt = S_SQY;
      S_SQY:  state_nxt = S_ITER;
      S_ITER: if (cnt_r == hdw_pkg::CNT_W'(ITERS - 1)) state_nxt = S_MODE;
      S_MODE: begin
        if (m3 == hdw_pkg::MODE_SOFT && cfg.hard_thr != 15'd0) state_nxt = S_DIV;
        else state_nxt = S_FIN;
      end
      S_DIV:  if (cnt_r == hdw_pkg::CNT_W'(hdw_pkg::DIV_BITS - 1)) state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= hdw_pkg::MODE_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_MODE) mode_r <= m3;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        hx_r  <= q_data.x;
        hy_r  <= q_data.y;
        cls_r <= q_data.cls;
        cnt_r <= '0;
        if (q_data.cls == hdw_pkg::CLS_YZERO) begin
          z_r <= q_data.x[15] ? hdw_pkg::ANGLE_PI : 17'sd0;
        end else if (q_data.cls == hdw_pkg::CLS_XZERO) begin
          z_r <= q_data.y[15] ? -hdw_pkg::ANGLE_HALF_PI : hdw_pkg::ANGLE_HALF_PI;
        end else if (!q_data.x[15]) begin
          z_r  <= 17'sd0;
          cx_r <= {{3{q_data.x[15]}}, q_data.x, 8'd0};
          cy_r <= {{3{q_data.y[15]}}, q_data.y, 8'd0};
        end else if (!q_data.y[15]) begin
          z_r  <= hdw_pkg::ANGLE_HALF_PI;
          cx_r <= {{3{q_data.y[15]}}, q_data.y, 8'd0};
          cy_r <= -{{3{q_data.x[15]}}, q_data.x, 8'd0};
        end else begin
          z_r  <= -hdw_pkg::ANGLE_HALF_PI;
          cx_r <= -{{3{q_data.y[15]}}, q_data.y, 8'd0};
          cy_r <= {{3{q_data.x[15]}}, q_data.x, 8'd0};
        end
      end
      S_SQX: begin
        v_r   <= 32'(sq);
        res_r <= '0;
        bit_r <= 32'h4000_0000;
      end
      S_SQY: v_r <= v_r + 32'(sq);
      S_ITER: begin
        cnt_r <= cnt_r + 1'b1;
        if (32'(cnt_r) < CORDIC_STEPS && cls_r == hdw_pkg::CLS_GEN) begin
          if (!cy_r[CW-1]) begin
            cx_r <= cx_r + ys;
            cy_r <= cy_r - xs;
            z_r  <= z_r + at;
          end else begin
            cx_r <= cx_r - ys;
            cy_r <= cy_r + xs;
            z_r  <= z_r - at;
          end
        end
        if (cnt_r < hdw_pkg::CNT_W'(16)) begin
          if (v_r >= trial) begin
            v_r   <= v_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
      end
      S_MODE: begin
        cnt_r  <= '0;
        base_r <= base_c;
        pos_r  <= zs > 17'sd0;
        num_r  <= 31'(prod) + 31'(cfg.hard_thr >> 1);
        rem_r  <= '0;
        dz_r   <= ~(m3 == hdw_pkg::MODE_SOFT && cfg.hard_thr != 15'd0);
      end
      S_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        rem_r <= qbit ? rem_sh - {1'b0, cfg.hard_thr} : rem_sh;
        num_r <= {num_r[29:0], qbit};
      end
      S_FIN: begin
        if (out_free) begin
          out_r.left_speed  <= sat16(lt);
          out_r.right_speed <= sat16(rt);
          out_r.turn_mode   <= mode_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- dv/hdw_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hdw_checker
// Watches the heading, wheel speed and register write ports of the heading to
// wheel speed block. It keeps its own copy of the registers and the turning
// mode and predicts each wheel speed beat from the accepted heading beat. It
// then compares every result field by field, in order.
// ----------------------------------------------------------------------------
module hdw_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  hdw_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  hdw_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_wdata,
  output int                 fail_count,
  output int                 speeds_pending,
  output int                 speeds_checked
);

  localparam int STEPS = 16;

  // atan(2^-i) in Q3.13, zero from step 14 on
  localparam longint ATAN_Q13 [14] = '{6434, 3798, 2007, 1019, 511, 256, 128,
                                        64, 32, 16, 8, 4, 2, 1};

  logic [14:0]        hard_thr, soft_thr, none_thr, top_speed;
  logic [1:0]         steer_mode;
  hdw_pkg::out_beat_t speed_q[$];

  // heading angle in Q3.13 radians by vectoring rotations
  function automatic longint heading_angle(longint hx, longint hy);
    longint x, y, z, nx, ny, xs, ys;
    if (hy == 0) return (hx >= 0) ? 0 : 25736;
    if (hx == 0) return (hy > 0) ? 12868 : -12868;
    x = hx * 256;
    y = hy * 256;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        nx = y; ny = -x; z = 12868;
      end else begin
        nx = -y; ny = x; z = -12868;
      end
      x = nx;
      y = ny;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs;
        if (i < 14) z += ATAN_Q13[i];
      end else begin
        x = x - ys; y = y + xs;
        if (i < 14) z -= ATAN_Q13[i];
      end
    end
    if (z > 25736) z = 25736;
    if (z < -25736) z = -25736;
    return z;
  endfunction

  // floor of the square root, result fits in 17 bits
  function automatic longint root_floor(longint v);
    longint r, t;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // next mode and wheel speeds for one heading, updates the mode copy
  function automatic hdw_pkg::out_beat_t wheel_speeds(hdw_pkg::in_beat_t hb);
    longint hx, hy, ang, mag, len, base, hard, d, s1, s2;
    logic [1:0] m;
    hdw_pkg::out_beat_t r;
    hx = hb.heading_x;
    hy = hb.heading_y;
    ang = heading_angle(hx, hy);
    mag = (ang < 0) ? -ang : ang;
    len = root_floor(hx * hx + hy * hy);
    base = (len < top_speed) ? len : longint'(top_speed);
    hard = hard_thr;
    m = steer_mode;
    if (m != hdw_pkg::MODE_SOFT && m != hdw_pkg::MODE_HARD) m = hdw_pkg::MODE_NONE;
    if (m == hdw_pkg::MODE_HARD && mag <= soft_thr) m = hdw_pkg::MODE_SOFT;
    if (m == hdw_pkg::MODE_SOFT) begin
      if (mag > hard) m = hdw_pkg::MODE_HARD;
      else if (mag <= none_thr) m = hdw_pkg::MODE_NONE;
    end
    if (m == hdw_pkg::MODE_NONE) begin
      if (mag > hard) m = hdw_pkg::MODE_HARD;
      else if (mag > none_thr) m = hdw_pkg::MODE_SOFT;
    end
    steer_mode = m;
    if (m == hdw_pkg::MODE_SOFT) begin
      d = (hard != 0) ? (base * mag + hard / 2) / hard : 0;
      s1 = base - d;
      s2 = base + d;
    end else if (m == hdw_pkg::MODE_HARD) begin
      s1 = -longint'(top_speed);
      s2 = top_speed;
    end else begin
      s1 = base;
      s2 = base;
    end
    if (ang > 0) begin
      r.left_speed = clip16(s1); r.right_speed = clip16(s2);
    end else begin
      r.left_speed = clip16(s2); r.right_speed = clip16(s1);
    end
    r.turn_mode = m;
    return r;
  endfunction

  assign speeds_pending = speed_q.size();

  always @(posedge clk) begin
    hdw_pkg::out_beat_t want;
    if (!rst_n) begin
      hard_thr   <= 15'd12868;
      soft_thr   <= 15'd10008;
      none_thr   <= 15'd1430;
      top_speed  <= 15'd2560;
      steer_mode = hdw_pkg::MODE_NONE;
      speed_q.delete();
      fail_count = 0;
      speeds_checked = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          hdw_pkg::REG_HARD: hard_thr  <= cfg_wdata;
          hdw_pkg::REG_SOFT: soft_thr  <= cfg_wdata;
          hdw_pkg::REG_NONE: none_thr  <= cfg_wdata;
          hdw_pkg::REG_MAX:  top_speed <= cfg_wdata;
          default: ;
        endcase
      end
      // heading beat accepted
      if (in_valid && !in_stall) speed_q.push_back(wheel_speeds(in_data));
      // wheel speed beat accepted
      if (out_valid && !out_stall) begin
        speeds_checked++;
        if (speed_q.size() == 0) begin
          $error("unexpected wheel speed beat %h", out_data);
          fail_count++;
        end else begin
          want = speed_q.pop_front();
          if (out_data.left_speed !== want.left_speed) begin
            $error("left_speed: expected %0d, got %0d", want.left_speed,
                   out_data.left_speed);
            fail_count++;
          end
          if (out_data.right_speed !== want.right_speed) begin
            $error("right_speed: expected %0d, got %0d", want.right_speed,
                   out_data.right_speed);
            fail_count++;
          end
          if (out_data.turn_mode !== want.turn_mode) begin
            $error("turn_mode: expected %0d, got %0d", want.turn_mode,
                   out_data.turn_mode);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives heading beats into the heading to wheel speed block under several
// register settings and random stalls on both sides; the checker predicts and
// compares every wheel speed beat.
// ----------------------------------------------------------------------------
module tb;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  hdw_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  hdw_pkg::out_beat_t out_data;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = hdw_pkg::REG_HARD;
  logic [14:0]        cfg_wdata = '0;

  int fail_count, speeds_pending, speeds_checked;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int beats_sent = 0;
  int quiet_cycles = 0;
  int walk_x = 256, walk_y = 0;

  always #1 clk = ~clk;

  heading_to_differential_wheel_speeds_core uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata
  );

  hdw_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .speeds_pending,
    .speeds_checked
  );

  // receiver stalls
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one heading beat, with an optional gap ahead of it
  task automatic send_heading(logic signed [15:0] hx, logic signed [15:0] hy);
    logic held;
    if (beats_sent < 400) begin
      send_idle_pct = 16; recv_idle_pct = 49;
    end else if (beats_sent < 800) begin
      send_idle_pct = 49; recv_idle_pct = 16;
    end else begin
      send_idle_pct = 0; recv_idle_pct = 0;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{heading_x: hx, heading_y: hy};
    forever begin
      @(negedge clk);
      held = in_stall;
      @(posedge clk);
      if (!held) break;
    end
    beats_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (speeds_pending != 0) @(posedge clk);
  endtask

  // all four registers, written only with the block idle
  task automatic set_regs(int hard, int relax, int none, int top);
    drain_results();
    repeat (80) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= hdw_pkg::REG_HARD; cfg_wdata <= hard[14:0];  @(posedge clk);
    cfg_index <= hdw_pkg::REG_SOFT; cfg_wdata <= relax[14:0]; @(posedge clk);
    cfg_index <= hdw_pkg::REG_NONE; cfg_wdata <= none[14:0];  @(posedge clk);
    cfg_index <= hdw_pkg::REG_MAX;  cfg_wdata <= top[14:0];   @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // random heading: half of them smooth sweeps to walk the mode through hysteresis
  task automatic send_random();
    int sel, span, hx, hy;
    sel = $urandom_range(9);
    if (sel <= 4) begin
      span = ($urandom_range(3) == 0) ? 4000 : 300;
      walk_x = clamp16(walk_x + $urandom_range(0, 2 * span) - span);
      walk_y = clamp16(walk_y + $urandom_range(0, 2 * span) - span);
      if ($urandom_range(15) == 0) begin
        walk_x = $urandom_range(0, 4000) - 2000;
        walk_y = $urandom_range(0, 4000) - 2000;
      end
      hx = walk_x; hy = walk_y;
    end else if (sel <= 6) begin
      hx = $signed(16'($urandom)); hy = $signed(16'($urandom));
    end else if (sel == 7) begin
      hx = $urandom_range(0, 8) - 4; hy = $urandom_range(0, 8) - 4;
    end else if (sel == 8) begin
      hx = $signed(16'($urandom));
      hy = 0;
      if ($urandom_range(1)) begin
        hy = hx; hx = 0;
      end
    end else begin
      hx = ($urandom_range(1) ? 32767 : -32768) - $urandom_range(0, 3);
      hy = ($urandom_range(1) ? 32767 : -32768) - $urandom_range(0, 3);
      hx = clamp16(hx); hy = clamp16(hy);
    end
    send_heading(hx[15:0], hy[15:0]);
  endtask

  initial begin
    int hard, relax, none;
    int corner_x [20] = '{0, 32767, -32768, 0, 0, -32768, 32767, -32768, 32767,
                          -1, 1, -1, 1, 256, 256, 0, -256, 256, 256, 256};
    int corner_y [20] = '{0, 0, 0, 32767, -32768, -32768, 32767, 32767, -32768,
                          1, -1, -1, 0, 40, 60, 256, 10, 200, 10, -60};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners, axes and a directed trip through soft and hard turning
    for (int i = 0; i < 20; i++) send_heading(corner_x[i][15:0], corner_y[i][15:0]);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: ;
        1: set_regs(0, 0, 0, 0);
        2: set_regs(25736, 25736, 25736, 32767);
        3: set_regs(32767, 32767, 32767, 32767);
        4: begin
          hard = $urandom_range(0, 25736);
          relax = $urandom_range(0, hard);
          none = $urandom_range(0, relax);
          set_regs(hard, relax, none, $urandom_range(0, 32767));
        end
        default: set_regs($urandom_range(0, 32767), $urandom_range(0, 32767),
                          $urandom_range(0, 32767), $urandom_range(0, 32767));
      endcase
      for (int k = 0; k < 190; k++) begin
        // sender holds off until the block has drained
        if (k == 95) drain_results();
        send_random();
      end
    end
    // back to the reset values with a short burst
    set_regs(12868, 10008, 1430, 2560);
    for (int k = 0; k < 40; k++) send_random();

    drain_results();
    repeat (120) @(posedge clk);
    $display("covered %0d heading beats, %0d wheel speed beats checked,",
             beats_sent, speeds_checked);
    $display("over seven register settings and three stall profiles");
    if (fail_count == 0 && speeds_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
design/hdw_pkg.sv
design/hdw_front.sv
design/hdw_queue.sv
design/hdw_back.sv
design/heading_to_differential_wheel_speeds_core.sv
dv/hdw_checker.sv
dv/tb.sv
